// File: design/pirs_pkg.sv
// package for the positional insert/remove stack
// holds the sizes, opcode and status codes, and the cell command type
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pirs_pkg;

	localparam int DEPTH      = 16;
	localparam int ELEM_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int POS_W      = 4;
	localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [2:0] {
		OP_PUSH     = 3'd0,
		OP_POP      = 3'd1,
		OP_INSERT   = 3'd2,
		OP_WITHDRAW = 3'd3,
		OP_CLEAR    = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_HOLD = 2'd0,
		CMD_INS  = 2'd1,
		CMD_DEL  = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [IDX_W-1:0] pos;
	} cell_cmd_t;

endpackage

`default_nettype wire

// File: design/pirs_cell.sv
// one storage cell of the stack chain
// takes its left or right neighbor, the new word, or holds; uses pirs_pkg
`timescale 1ns / 1ps
`default_nettype none

module pirs_cell (
	input  wire logic                             clk,
	input  wire pirs_pkg::cell_cmd_t              cmd,
	input  wire logic [pirs_pkg::IDX_W-1:0]       idx,
	input  wire logic [pirs_pkg::ELEM_WIDTH-1:0]  value,
	input  wire logic [pirs_pkg::ELEM_WIDTH-1:0]  left,
	input  wire logic [pirs_pkg::ELEM_WIDTH-1:0]  right,
	output logic      [pirs_pkg::ELEM_WIDTH-1:0]  data_q
);

	always_ff @(posedge clk) begin
		unique case (cmd.kind)
			pirs_pkg::CMD_INS: begin
				if (idx == cmd.pos) begin
					data_q <= value;
				end else if (idx > cmd.pos) begin
					data_q <= left;
				end
			end
			pirs_pkg::CMD_DEL: begin
				// entries above the withdrawn one slide down
				if (idx >= cmd.pos) begin
					data_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// File: design/positional_insert_remove_stack.sv
// top level of the positional insert/remove stack
// request decode, fill count, cell chain and result register; uses pirs_pkg, pirs_cell
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request word: opcode,
//   push_value and position. Output channel (out_valid / out_stall) returns
//   exactly one result word per request: status, out_value, fill_level.
//   Push and insert at position p shift the cells at and above p up one
//   place; withdraw at p shifts the cells above p down one place. All cells
//   move together in the same clock, so one request is taken every cycle
//   while the input is not stalled. The result appears in the cycle after
//   the request is accepted. The result register sets the rate of one
//   request per cycle; the element returned is a single indexed read.
//   The input is stalled only while a result waits and the receiver
//   stalls; a result being taken frees the register for a new one in the
//   same cycle.
//   Reset empties the stack (fill count zero) and drops any pending
//   result. Cell contents are not cleared; cells at or above the fill
//   count are never returned.
`timescale 1ns / 1ps
`default_nettype none

module positional_insert_remove_stack (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  opcode,
	input  wire logic [31:0] push_value,
	input  wire logic [3:0]  position,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       status,
	output logic [31:0]      out_value,
	output logic [4:0]       fill_level
);

	localparam int DEPTH = pirs_pkg::DEPTH;
	localparam int EW    = pirs_pkg::ELEM_WIDTH;
	localparam int IDX_W = pirs_pkg::IDX_W;
	localparam int CNT_W = pirs_pkg::CNT_W;
	localparam int CMP_W = pirs_pkg::CMP_W;

	logic [CNT_W-1:0]    fill_q;
	logic                out_valid_q;
	pirs_pkg::status_t   status_q;
	logic [31:0]         value_q;
	logic [4:0]          level_q;

	logic [EW-1:0]       cell_data [DEPTH];
	pirs_pkg::cell_cmd_t cmd;
	logic                accept;
	logic [CMP_W-1:0]    pos_w;
	logic [CMP_W-1:0]    fill_w;
	logic [IDX_W-1:0]    rd_idx;
	logic [EW-1:0]       rd_data;
	logic [EW-1:0]       elem_in;
	pirs_pkg::status_t   st_next;
	logic [31:0]         val_next;
	logic [CNT_W-1:0]    fill_next;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	assign pos_w   = CMP_W'(position);
	assign fill_w  = CMP_W'(fill_q);
	assign elem_in = EW'(push_value);
	assign rd_data = cell_data[rd_idx];

	always_comb begin
		cmd.kind  = pirs_pkg::CMD_HOLD;
		cmd.pos   = IDX_W'(position);
		st_next   = pirs_pkg::ST_OK;
		val_next  = '0;
		fill_next = fill_q;
		rd_idx    = IDX_W'(position);
		unique case (pirs_pkg::op_t'(opcode))
			pirs_pkg::OP_PUSH: begin
				if (fill_q == CNT_W'(DEPTH)) begin
					st_next = pirs_pkg::ST_FULL;
				end else begin
					// push is an insert at the top
					cmd.kind  = pirs_pkg::CMD_INS;
					cmd.pos   = IDX_W'(fill_q);
					fill_next = fill_q + 1'b1;
				end
			end
			pirs_pkg::OP_POP: begin
				rd_idx = IDX_W'(fill_q - 1'b1);
				if (fill_q == '0) begin
					st_next = pirs_pkg::ST_EMPTY;
				end else begin
					val_next  = 32'(rd_data);
					fill_next = fill_q - 1'b1;
				end
			end
			pirs_pkg::OP_INSERT: begin
				if (fill_q == CNT_W'(DEPTH)) begin
					st_next = pirs_pkg::ST_FULL;
				end else if (pos_w > fill_w) begin
					st_next = pirs_pkg::ST_BADPOS;
				end else begin
					cmd.kind  = pirs_pkg::CMD_INS;
					fill_next = fill_q + 1'b1;
				end
			end
			pirs_pkg::OP_WITHDRAW: begin
				if (fill_q == '0) begin
					st_next = pirs_pkg::ST_EMPTY;
				end else if (pos_w >= fill_w) begin
					st_next = pirs_pkg::ST_BADPOS;
				end else begin
					cmd.kind  = pirs_pkg::CMD_DEL;
					val_next  = 32'(rd_data);
					fill_next = fill_q - 1'b1;
				end
			end
			pirs_pkg::OP_CLEAR: begin
				fill_next = '0;
			end
			default: begin
			end
		endcase
		if (!accept) begin
			cmd.kind = pirs_pkg::CMD_HOLD;
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [EW-1:0] left_w;
		logic [EW-1:0] right_w;
		if (i == 0) begin : g_lo
			assign left_w = cell_data[i];
		end else begin : g_lo
			assign left_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_hi
			assign right_w = cell_data[i];
		end else begin : g_hi
			assign right_w = cell_data[i+1];
		end
		pirs_cell u_cell (
			.clk    (clk),
			.cmd    (cmd),
			.idx    (IDX_W'(i)),
			.value  (elem_in),
			.left   (left_w),
			.right  (right_w),
			.data_q (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q      <= fill_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= st_next;
			value_q  <= val_next;
			level_q  <= 5'(fill_next);
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign out_value  = value_q;
	assign fill_level = level_q;

endmodule

`default_nettype wire

// File: sim/positional_insert_remove_stack_checker.sv
// checker for the positional insert/remove stack: watches both channels,
// keeps its own copy of the stack and compares every result word
// depends on pirs_pkg
`timescale 1ns / 1ps

module positional_insert_remove_stack_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [2:0]  opcode,
	input  wire logic [31:0] push_value,
	input  wire logic [3:0]  position,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [1:0]  status,
	input  wire logic [31:0] out_value,
	input  wire logic [4:0]  fill_level,
	output int               fail_count,
	output int               outstanding
);

	import pirs_pkg::*;

	typedef struct {
		status_t     st;
		logic [31:0] value;
		logic [4:0]  level;
	} stack_answer_t;

	logic [31:0]   stack_shadow [DEPTH];
	int            depth_used = 0;
	stack_answer_t answers_due [$];

	initial begin
		fail_count  = 0;
		outstanding = 0;
	end

	task automatic model_request(input logic [2:0] op, input logic [31:0] val,
			input logic [3:0] pos);
		stack_answer_t a;
		int i;
		a.st    = ST_OK;
		a.value = '0;
		case (op)
			OP_PUSH: begin
				if (depth_used >= DEPTH) begin
					a.st = ST_FULL;
				end else begin
					stack_shadow[depth_used] = val;
					depth_used++;
				end
			end
			OP_POP: begin
				if (depth_used == 0) begin
					a.st = ST_EMPTY;
				end else begin
					depth_used--;
					a.value = stack_shadow[depth_used];
				end
			end
			OP_INSERT: begin
				// full check wins over the position check
				if (depth_used >= DEPTH) begin
					a.st = ST_FULL;
				end else if (int'(pos) > depth_used) begin
					a.st = ST_BADPOS;
				end else begin
					for (i = depth_used; i > int'(pos); i--)
						stack_shadow[i] = stack_shadow[i-1];
					stack_shadow[pos] = val;
					depth_used++;
				end
			end
			OP_WITHDRAW: begin
				if (depth_used == 0) begin
					a.st = ST_EMPTY;
				end else if (int'(pos) >= depth_used) begin
					a.st = ST_BADPOS;
				end else begin
					a.value = stack_shadow[pos];
					for (i = int'(pos); i + 1 < depth_used; i++)
						stack_shadow[i] = stack_shadow[i+1];
					depth_used--;
				end
			end
			OP_CLEAR: depth_used = 0;
			default: ;
		endcase
		a.level = depth_used[4:0];
		answers_due.push_back(a);
	endtask

	task automatic check_result();
		stack_answer_t a;
		if (answers_due.size() == 0) begin
			$error("result word with no request pending: status %0d value %h level %0d",
				status, out_value, fill_level);
			fail_count++;
		end else begin
			a = answers_due.pop_front();
			if (status !== a.st) begin
				$error("status mismatch: expected %0d, got %0d", a.st, status);
				fail_count++;
			end
			if (out_value !== a.value) begin
				$error("out_value mismatch: expected %h, got %h", a.value, out_value);
				fail_count++;
			end
			if (fill_level !== a.level) begin
				$error("fill_level mismatch: expected %0d, got %0d", a.level, fill_level);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			answers_due.delete();
			depth_used = 0;
		end else begin
			// the result is registered, so a word taken now never answers this edge's request
			if (out_valid && !out_stall)
				check_result();
			if (in_valid && !in_stall)
				model_request(opcode, push_value, position);
		end
		outstanding = answers_due.size();
	end

endmodule

// File: sim/positional_insert_remove_stack_tb.sv
// testbench top for the positional insert/remove stack: clock, reset,
// request stimulus with bursty sender and stalling receiver, final verdict
// depends on pirs_pkg, positional_insert_remove_stack and its checker
`timescale 1ns / 1ps

module positional_insert_remove_stack_tb;

	import pirs_pkg::*;

	typedef enum int {GROW, SHRINK, MIXED} phase_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  opcode = 3'd0;
	logic [31:0] push_value = 32'd0;
	logic [3:0]  position = 4'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic [31:0] out_value;
	logic [4:0]  fill_level;
	int          fail_count;
	int          outstanding;

	int requests_sent = 0;
	int burst_left = 0;

	positional_insert_remove_stack DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.push_value (push_value),
		.position   (position),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.out_value  (out_value),
		.fill_level (fill_level)
	);

	positional_insert_remove_stack_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.push_value (push_value),
		.position   (position),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.out_value  (out_value),
		.fill_level (fill_level),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic send_request(input logic [2:0] op, input logic [31:0] val,
			input logic [3:0] pos);
		in_valid   <= 1'b1;
		opcode     <= op;
		push_value <= val;
		position   <= pos;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (op <= OP_CLEAR)
			requests_sent++;
	endtask

	// bursts of back-to-back words separated by random gaps
	task automatic send_bursty(input logic [2:0] op, input logic [31:0] val,
			input logic [3:0] pos);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		send_request(op, val, pos);
	endtask

	function automatic logic [2:0] pick_op(input phase_t mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			GROW: begin
				if (r < 45) return OP_PUSH;
				if (r < 85) return OP_INSERT;
				if (r < 92) return OP_POP;
				return OP_WITHDRAW;
			end
			SHRINK: begin
				if (r < 40) return OP_POP;
				if (r < 85) return OP_WITHDRAW;
				if (r < 92) return OP_PUSH;
				return OP_INSERT;
			end
			default: begin
				if (r < 3) return OP_CLEAR;
				if (r < 6) return 3'($urandom_range(5, 7));
				if (r < 30) return OP_PUSH;
				if (r < 53) return OP_POP;
				if (r < 77) return OP_INSERT;
				return OP_WITHDRAW;
			end
		endcase
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		phase_t mode;
		int phase_len;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty stack corners, append by insert, bad positions, unused codes
		send_request(OP_POP,      32'hDEAD_BEEF, 4'd0);
		send_request(OP_WITHDRAW, 32'h0,         4'd0);
		send_request(OP_INSERT,   32'h1111_1111, 4'd1);
		send_request(OP_INSERT,   32'hFFFF_FFFF, 4'd0);
		send_request(OP_PUSH,     32'h0,         4'd15);
		send_request(OP_PUSH,     32'hA5A5_5A5A, 4'd0);
		send_request(OP_INSERT,   32'h8000_0001, 4'd3);
		send_request(OP_INSERT,   32'h7FFF_FFFE, 4'd15);
		send_request(OP_INSERT,   32'h1234_5678, 4'd1);
		send_request(OP_WITHDRAW, 32'h0,         4'd5);
		send_request(OP_WITHDRAW, 32'h0,         4'd4);
		send_request(OP_WITHDRAW, 32'h0,         4'd0);
		send_request(OP_POP,      32'h0,         4'd0);
		send_request(3'd5,        32'hFFFF_FFFF, 4'd0);
		send_request(3'd6,        32'h0,         4'd15);
		send_request(3'd7,        32'h5555_AAAA, 4'd7);
		send_request(OP_CLEAR,    32'h0,         4'd0);
		send_request(OP_POP,      32'h0,         4'd0);
		send_request(OP_PUSH,     $urandom,      4'd8);
		send_request(OP_WITHDRAW, 32'h0,         4'd15);
		send_request(OP_CLEAR,    32'hFFFF_FFFF, 4'd15);

		// random phases; the first one grows the stack past full
		mode = GROW;
		phase_len = 40;
		while (requests_sent < 1420) begin
			repeat (phase_len)
				send_bursty(pick_op(mode), pick_value(), 4'($urandom_range(0, 15)));
			mode = phase_t'($urandom_range(0, 2));
			phase_len = $urandom_range(20, 80);
		end

		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("positional_insert_remove_stack_tb OK");
		else
			$display("positional_insert_remove_stack_tb NOT OK");
		$finish;
	end

	// receiver back-pressure, pattern changes every so often
	initial begin
		int pattern;
		int len;
		int k;
		forever begin
			pattern = $urandom_range(0, 3);
			len = $urandom_range(20, 120);
			for (k = 0; k < len; k++) begin
				@(negedge clk);
				case (pattern)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 99) < 30);
					2: out_stall <= ($urandom_range(0, 99) < 75);
					default: out_stall <= (k % 4 != 0);
				endcase
			end
		end
	end

	initial begin
		#2_000_000;
		$display("positional_insert_remove_stack_tb NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
design/pirs_pkg.sv
design/pirs_cell.sv
design/positional_insert_remove_stack.sv
sim/positional_insert_remove_stack_checker.sv
sim/positional_insert_remove_stack_tb.sv
